// ===== src/dbdf_pkg.sv =====
// Shared types and constants of the detection box decode and filter block.
// Used by the front, back and top-level modules; depends on nothing else.
package dbdf_pkg;

    localparam int CFG_DATA_W = 16;
    localparam int BOX_IDX_W  = 13;
    localparam int CLASS_W    = 8;
    localparam int SCORE_W    = 16;
    localparam int COORD_W    = 12;
    localparam int CORNER_W   = 20;
    localparam int QUO_W      = 24;
    localparam int DIV_STEPS  = 24;

    typedef struct packed {
        logic [15:0] score_threshold;
        logic [14:0] pad_left;
        logic [14:0] pad_top;
        logic [15:0] scale_factor;
        logic [12:0] image_width;
        logic [12:0] image_height;
    } t_cfg;

    typedef struct packed {
        logic [BOX_IDX_W-1:0]           box_index;
        logic [CLASS_W-1:0]             class_index;
        logic [SCORE_W-1:0]             confidence;
        logic [3:0][CORNER_W-1:0]       corner;
    } t_job;

    typedef struct packed {
        logic [BOX_IDX_W-1:0] box_index;
        logic [CLASS_W-1:0]   class_index;
        logic [SCORE_W-1:0]   confidence;
        logic [COORD_W-1:0]   left;
        logic [COORD_W-1:0]   top;
        logic [COORD_W-1:0]   right;
        logic [COORD_W-1:0]   bottom;
    } t_result;

endpackage

// ===== src/dbdf_fifo.sv =====
// Small register-based first-in first-out queue for packed words.
// Used between the front and back parts and on the result side; no dependencies.
module dbdf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== src/dbdf_front.sv =====
// Front part: running best score per box, class and box counters, and the
// padded corners of every kept box. Depends on dbdf_pkg.
module dbdf_front #(
    parameter int MAX_CLASSES = 128,
    parameter int MAX_BOXES   = 8192
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dbdf_pkg::t_cfg       i_cfg,
    input  logic                 i_accept,
    input  logic signed [15:0]   i_centre_x,
    input  logic signed [15:0]   i_centre_y,
    input  logic signed [15:0]   i_box_width,
    input  logic signed [15:0]   i_box_height,
    input  logic [15:0]          i_score,
    input  logic                 i_last_score,
    input  logic                 i_last_box,
    output logic                 o_job_push,
    output dbdf_pkg::t_job       o_job
);
    localparam int CW = dbdf_pkg::CORNER_W;

    logic [15:0]                      r_best_score;
    logic [dbdf_pkg::CLASS_W-1:0]     r_best_class;
    logic [6:0]                       r_class_cnt;
    logic [dbdf_pkg::BOX_IDX_W-1:0]   r_box_cnt;
    logic [15:0]                      n_best_score;
    logic [dbdf_pkg::CLASS_W-1:0]     n_best_class;
    logic [CW-1:0]                    cx2;
    logic [CW-1:0]                    cy2;
    logic [CW-1:0]                    bw;
    logic [CW-1:0]                    bh;
    logic [CW-1:0]                    px2;
    logic [CW-1:0]                    py2;

    always_comb begin
        if (i_score > r_best_score) begin
            n_best_score = i_score;
            n_best_class = {1'b0, r_class_cnt};
        end else begin
            n_best_score = r_best_score;
            n_best_class = r_best_class;
        end
    end

    assign cx2 = {{(CW - 17){i_centre_x[15]}}, i_centre_x, 1'b0};
    assign cy2 = {{(CW - 17){i_centre_y[15]}}, i_centre_y, 1'b0};
    assign bw  = {{(CW - 16){i_box_width[15]}}, i_box_width};
    assign bh  = {{(CW - 16){i_box_height[15]}}, i_box_height};
    assign px2 = {{(CW - 16){1'b0}}, i_cfg.pad_left, 1'b0};
    assign py2 = {{(CW - 16){1'b0}}, i_cfg.pad_top, 1'b0};

    assign o_job_push = i_accept && i_last_score
                        && (n_best_score >= i_cfg.score_threshold);

    always_comb begin
        o_job.box_index   = r_box_cnt;
        o_job.class_index = n_best_class;
        o_job.confidence  = n_best_score;
        o_job.corner[0]   = cx2 - bw - px2;
        o_job.corner[1]   = cx2 + bw - px2;
        o_job.corner[2]   = cy2 - bh - py2;
        o_job.corner[3]   = cy2 + bh - py2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_score <= '0;
            r_best_class <= '1;
            r_class_cnt  <= '0;
            r_box_cnt    <= '0;
        end else if (i_accept) begin
            if (i_last_score) begin
                r_best_score <= '0;
                r_best_class <= '1;
                r_class_cnt  <= '0;
                if (i_last_box || r_box_cnt == dbdf_pkg::BOX_IDX_W'(MAX_BOXES - 1)) begin
                    r_box_cnt <= '0;
                end else begin
                    r_box_cnt <= r_box_cnt + 1'b1;
                end
            end else begin
                r_best_score <= n_best_score;
                r_best_class <= n_best_class;
                if (r_class_cnt == 7'(MAX_CLASSES - 1)) begin
                    r_class_cnt <= '0;
                end else begin
                    r_class_cnt <= r_class_cnt + 1'b1;
                end
            end
        end
    end

endmodule

// ===== src/dbdf_back.sv =====
// Back part: divides the four corners of a kept box by the scale, one
// quotient bit per cycle, then clamps, orders and emits the box. Depends on dbdf_pkg.
module dbdf_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dbdf_pkg::t_cfg       i_cfg,
    input  logic                 i_job_empty,
    input  dbdf_pkg::t_job       i_job,
    output logic                 o_job_pop,
    input  logic                 i_out_full,
    output logic                 o_out_push,
    output dbdf_pkg::t_result    o_result
);
    localparam int QW = dbdf_pkg::QUO_W;
    localparam int XW = dbdf_pkg::COORD_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_PUSH
    } t_state;

    t_state              r_state;
    dbdf_pkg::t_job      r_job;
    logic [1:0]          r_sel;
    logic [4:0]          r_step;
    logic [15:0]         r_rem;
    logic [QW-1:0]       r_quo;
    logic [XW-1:0]       r_edge [4];
    logic [15:0]         divisor;
    logic [16:0]         trial;
    logic [16:0]         diff;
    logic                ge;
    logic [QW-1:0]       quotient;
    logic [XW-1:0]       bound_x;
    logic [XW-1:0]       bound_y;
    logic [XW-1:0]       bound;
    logic [XW-1:0]       edge_val;
    logic [1:0]          n_sel;

    function automatic logic [XW-1:0] clamp_bound(input logic [12:0] size);
        logic [12:0] dec;
        dec = size - 1'b1;
        if (size == '0) begin
            return '0;
        end else if (dec[12]) begin
            return '1;
        end else begin
            return dec[XW-1:0];
        end
    endfunction

    function automatic logic [QW-1:0] dividend(input logic [dbdf_pkg::CORNER_W-1:0] c);
        if (c[dbdf_pkg::CORNER_W-1]) begin
            return '0;
        end else begin
            return {c[16:0], 7'b0};
        end
    endfunction

    assign divisor  = (i_cfg.scale_factor == '0) ? 16'd1 : i_cfg.scale_factor;
    assign trial    = {r_rem, r_quo[QW-1]};
    assign ge       = (trial >= {1'b0, divisor});
    assign diff     = trial - {1'b0, divisor};
    assign quotient = {r_quo[QW-2:0], ge};
    assign bound_x  = clamp_bound(i_cfg.image_width);
    assign bound_y  = clamp_bound(i_cfg.image_height);
    assign bound    = r_sel[1] ? bound_y : bound_x;
    assign edge_val = (quotient > {{(QW - XW){1'b0}}, bound}) ? bound : quotient[XW-1:0];
    assign n_sel    = r_sel + 1'b1;

    assign o_job_pop  = (r_state == S_IDLE) && !i_job_empty;
    assign o_out_push = (r_state == S_PUSH) && !i_out_full;

    always_comb begin
        o_result.box_index   = r_job.box_index;
        o_result.class_index = r_job.class_index;
        o_result.confidence  = r_job.confidence;
        o_result.left   = (r_edge[0] < r_edge[1]) ? r_edge[0] : r_edge[1];
        o_result.right  = (r_edge[0] < r_edge[1]) ? r_edge[1] : r_edge[0];
        o_result.top    = (r_edge[2] < r_edge[3]) ? r_edge[2] : r_edge[3];
        o_result.bottom = (r_edge[2] < r_edge[3]) ? r_edge[3] : r_edge[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= '0;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_job_empty) begin
                        r_job   <= i_job;
                        r_sel   <= '0;
                        r_step  <= '0;
                        r_rem   <= '0;
                        r_quo   <= dividend(i_job.corner[0]);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem  <= ge ? diff[15:0] : trial[15:0];
                    r_quo  <= quotient;
                    r_step <= r_step + 1'b1;
                    if (r_step == 5'(dbdf_pkg::DIV_STEPS - 1)) begin
                        r_edge[r_sel] <= edge_val;
                        if (r_sel == 2'd3) begin
                            r_state <= S_PUSH;
                        end else begin
                            r_sel  <= n_sel;
                            r_step <= '0;
                            r_rem  <= '0;
                            r_quo  <= dividend(r_job.corner[n_sel]);
                        end
                    end
                end
                S_PUSH: begin
                    if (!i_out_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== src/detection_box_decode_filter.sv =====
// Top level of the detection box decode and filter block: configuration
// registers, front and back parts and the queues between them.
// Depends on dbdf_pkg, dbdf_fifo, dbdf_front and dbdf_back.
//
// Input side: one class score per word, with the box centre and size held on
// every word; a word is taken at a clock edge with push high and full low.
// A word that carries last_score closes the box; if its best score reaches the
// threshold, the box goes into a two-entry job queue.
// Throughput: one score word per cycle while full is low. full is high
// while the job queue holds two boxes not yet started by the back part.
// The back part takes a box from the job queue, divides its four corners one
// after another with one restoring divider at one quotient bit per cycle, and
// then writes the result into the output queue, waiting while that queue is
// full; it takes no new box until that result is written. A result is shown
// while empty is low; it leaves at an edge with pop high. If the receiver
// stalls, the output queue (two entries) and then the job queue fill, and full
// rises; nothing is lost. Reset (synchronous, active low) loads the default
// configuration, clears the running best score, the counters and both queues.
// The user must write configuration through i_cfg_wr_en, i_cfg_index and
// i_cfg_data only while the block is idle; the block does not enforce this.
module detection_box_decode_filter #(
    parameter int MAX_CLASSES = 128,
    parameter int MAX_BOXES   = 8192
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [2:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    input  logic                 push,
    output logic                 full,
    input  logic signed [15:0]   i_centre_x,
    input  logic signed [15:0]   i_centre_y,
    input  logic signed [15:0]   i_box_width,
    input  logic signed [15:0]   i_box_height,
    input  logic [15:0]          i_score,
    input  logic                 i_last_score,
    input  logic                 i_last_box,
    output logic                 empty,
    input  logic                 pop,
    output logic [12:0]          o_box_index,
    output logic signed [7:0]    o_class_index,
    output logic [15:0]          o_confidence,
    output logic [11:0]          o_left,
    output logic [11:0]          o_top,
    output logic [11:0]          o_right,
    output logic [11:0]          o_bottom
);
    localparam logic [2:0] REG_SCORE_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_PAD_LEFT        = 3'd1;
    localparam logic [2:0] REG_PAD_TOP         = 3'd2;
    localparam logic [2:0] REG_SCALE_FACTOR    = 3'd3;
    localparam logic [2:0] REG_IMAGE_WIDTH     = 3'd4;
    localparam logic [2:0] REG_IMAGE_HEIGHT    = 3'd5;
    localparam int JOB_W = $bits(dbdf_pkg::t_job);
    localparam int RES_W = $bits(dbdf_pkg::t_result);

    dbdf_pkg::t_cfg     r_cfg;
    dbdf_pkg::t_job     front_job;
    dbdf_pkg::t_job     back_job;
    dbdf_pkg::t_result  back_result;
    dbdf_pkg::t_result  out_result;
    logic [JOB_W-1:0]   job_q_data;
    logic [RES_W-1:0]   res_q_data;
    logic               accept;
    logic               job_push;
    logic               job_pop;
    logic               job_empty;
    logic               res_push;
    logic               res_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.score_threshold <= 16'd16384;
            r_cfg.pad_left        <= '0;
            r_cfg.pad_top         <= '0;
            r_cfg.scale_factor    <= 16'd4096;
            r_cfg.image_width     <= 13'd640;
            r_cfg.image_height    <= 13'd640;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_SCORE_THRESHOLD: r_cfg.score_threshold <= i_cfg_data;
                REG_PAD_LEFT:        r_cfg.pad_left        <= i_cfg_data[14:0];
                REG_PAD_TOP:         r_cfg.pad_top         <= i_cfg_data[14:0];
                REG_SCALE_FACTOR:    r_cfg.scale_factor    <= i_cfg_data;
                REG_IMAGE_WIDTH:     r_cfg.image_width     <= i_cfg_data[12:0];
                REG_IMAGE_HEIGHT:    r_cfg.image_height    <= i_cfg_data[12:0];
                default: begin
                end
            endcase
        end
    end

    assign accept = push && !full;

    dbdf_front #(
        .MAX_CLASSES (MAX_CLASSES),
        .MAX_BOXES   (MAX_BOXES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_accept     (accept),
        .i_centre_x   (i_centre_x),
        .i_centre_y   (i_centre_y),
        .i_box_width  (i_box_width),
        .i_box_height (i_box_height),
        .i_score      (i_score),
        .i_last_score (i_last_score),
        .i_last_box   (i_last_box),
        .o_job_push   (job_push),
        .o_job        (front_job)
    );

    dbdf_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (2)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (front_job),
        .o_full  (full),
        .i_pop   (job_pop),
        .o_empty (job_empty),
        .o_data  (job_q_data)
    );

    assign back_job = dbdf_pkg::t_job'(job_q_data);

    dbdf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_empty (job_empty),
        .i_job       (back_job),
        .o_job_pop   (job_pop),
        .i_out_full  (res_full),
        .o_out_push  (res_push),
        .o_result    (back_result)
    );

    dbdf_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_result),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (res_q_data)
    );

    assign out_result    = dbdf_pkg::t_result'(res_q_data);
    assign o_box_index   = out_result.box_index;
    assign o_class_index = out_result.class_index;
    assign o_confidence  = out_result.confidence;
    assign o_left        = out_result.left;
    assign o_top         = out_result.top;
    assign o_right       = out_result.right;
    assign o_bottom      = out_result.bottom;

endmodule

// ===== verif/detection_box_decode_filter_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of detection_box_decode_filter: streams score words,
// predicts every kept box and compares each result word field by field.
// Depends on dbdf_pkg and the RTL of the block.
module detection_box_decode_filter_tb;

    typedef enum logic [2:0] {
        REG_THRESHOLD = 3'd0,
        REG_PAD_LEFT  = 3'd1,
        REG_PAD_TOP   = 3'd2,
        REG_SCALE     = 3'd3,
        REG_IMAGE_W   = 3'd4,
        REG_IMAGE_H   = 3'd5,
        REG_SPARE_A   = 3'd6,
        REG_SPARE_B   = 3'd7
    } t_cfg_reg;

    typedef struct {
        logic signed [15:0] centre_x;
        logic signed [15:0] centre_y;
        logic signed [15:0] box_width;
        logic signed [15:0] box_height;
        logic [15:0]        score;
        logic               last_score;
        logic               last_box;
    } t_score_word;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_wr_en;
    logic [2:0]         i_cfg_index;
    logic [15:0]        i_cfg_data;
    logic               push = 1'b0;
    logic               full;
    logic signed [15:0] i_centre_x = '0;
    logic signed [15:0] i_centre_y = '0;
    logic signed [15:0] i_box_width = '0;
    logic signed [15:0] i_box_height = '0;
    logic [15:0]        i_score = '0;
    logic               i_last_score = 1'b0;
    logic               i_last_box = 1'b0;
    logic               empty;
    logic               pop = 1'b0;
    logic [12:0]        o_box_index;
    logic signed [7:0]  o_class_index;
    logic [15:0]        o_confidence;
    logic [11:0]        o_left;
    logic [11:0]        o_top;
    logic [11:0]        o_right;
    logic [11:0]        o_bottom;

    logic [15:0] cfg_threshold;
    logic [14:0] cfg_pad_left;
    logic [14:0] cfg_pad_top;
    logic [15:0] cfg_scale;
    logic [12:0] cfg_img_w;
    logic [12:0] cfg_img_h;

    logic [15:0] run_best = '0;
    logic [7:0]  run_class = '1;
    logic [6:0]  class_pos = '0;
    logic [12:0] box_pos = '0;

    t_score_word        pending_words[$];
    t_score_word        word_on_bus;
    dbdf_pkg::t_result  expected_boxes[$];
    dbdf_pkg::t_result  oldest_box;

    bit idle_on = 1'b1;
    int mismatches = 0;
    int words_taken = 0;
    int boxes_checked = 0;
    int settings_used = 1;

    detection_box_decode_filter i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .push          (push),
        .full          (full),
        .i_centre_x    (i_centre_x),
        .i_centre_y    (i_centre_y),
        .i_box_width   (i_box_width),
        .i_box_height  (i_box_height),
        .i_score       (i_score),
        .i_last_score  (i_last_score),
        .i_last_box    (i_last_box),
        .empty         (empty),
        .pop           (pop),
        .o_box_index   (o_box_index),
        .o_class_index (o_class_index),
        .o_confidence  (o_confidence),
        .o_left        (o_left),
        .o_top         (o_top),
        .o_right       (o_right),
        .o_bottom      (o_bottom)
    );

    always #2 i_clk = ~i_clk;

    function automatic int unsigned clamp_bound(input logic [12:0] size);
        int unsigned s;
        s = size;
        if (s == 0) return 0;
        if (s - 1 > 4095) return 4095;
        return s - 1;
    endfunction

    function automatic logic [11:0] to_pixel(input longint corner, input int unsigned bound);
        longint unsigned div;
        longint unsigned q;
        div = (cfg_scale == 16'd0) ? 64'd1 : 64'(cfg_scale);
        if (corner < 0) return 12'd0;
        q = corner;
        q = q * 128 / div;
        if (q > bound) return bound[11:0];
        return q[11:0];
    endfunction

    task automatic predict_box_word(input t_score_word w);
        dbdf_pkg::t_result r;
        int unsigned bx;
        int unsigned by;
        logic [11:0] x1;
        logic [11:0] x2;
        logic [11:0] y1;
        logic [11:0] y2;
        if (w.score > run_best) begin
            run_best = w.score;
            run_class = {1'b0, class_pos};
        end
        class_pos = class_pos + 1'b1;
        if (w.last_score) begin
            if (run_best >= cfg_threshold) begin
                bx = clamp_bound(cfg_img_w);
                by = clamp_bound(cfg_img_h);
                x1 = to_pixel(2 * longint'(w.centre_x) - longint'(w.box_width)
                              - 2 * longint'(cfg_pad_left), bx);
                x2 = to_pixel(2 * longint'(w.centre_x) + longint'(w.box_width)
                              - 2 * longint'(cfg_pad_left), bx);
                y1 = to_pixel(2 * longint'(w.centre_y) - longint'(w.box_height)
                              - 2 * longint'(cfg_pad_top), by);
                y2 = to_pixel(2 * longint'(w.centre_y) + longint'(w.box_height)
                              - 2 * longint'(cfg_pad_top), by);
                r.box_index = box_pos;
                r.class_index = run_class;
                r.confidence = run_best;
                r.left = (x1 < x2) ? x1 : x2;
                r.right = (x1 < x2) ? x2 : x1;
                r.top = (y1 < y2) ? y1 : y2;
                r.bottom = (y1 < y2) ? y2 : y1;
                expected_boxes = {expected_boxes, r};
            end
            run_best = '0;
            run_class = '1;
            class_pos = '0;
            box_pos = w.last_box ? 13'd0 : box_pos + 1'b1;
        end
    endtask

    task automatic add_word(input logic signed [15:0] cx, input logic signed [15:0] cy,
                            input logic signed [15:0] bw, input logic signed [15:0] bh,
                            input logic [15:0] sc, input logic ls, input logic lb);
        t_score_word w;
        w.centre_x = cx;
        w.centre_y = cy;
        w.box_width = bw;
        w.box_height = bh;
        w.score = sc;
        w.last_score = ls;
        w.last_box = lb;
        pending_words = {pending_words, w};
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [15:0] data);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_THRESHOLD: cfg_threshold = data;
            REG_PAD_LEFT:  cfg_pad_left = data[14:0];
            REG_PAD_TOP:   cfg_pad_top = data[14:0];
            REG_SCALE:     cfg_scale = data;
            REG_IMAGE_W:   cfg_img_w = data[12:0];
            REG_IMAGE_H:   cfg_img_h = data[12:0];
            default: begin
            end
        endcase
    endtask

    task automatic close_cfg();
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        settings_used++;
        @(negedge i_clk);
    endtask

    task automatic settle();
        do @(negedge i_clk);
        while (pending_words.size() != 0 || push || expected_boxes.size() != 0);
        repeat (110) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                predict_box_word(word_on_bus);
                words_taken++;
            end
            if (!push || !full) begin
                if (pending_words.size() != 0 && !(idle_on && $urandom_range(0, 99) < 17)) begin
                    word_on_bus = pending_words.pop_front();
                    i_centre_x <= word_on_bus.centre_x;
                    i_centre_y <= word_on_bus.centre_y;
                    i_box_width <= word_on_bus.box_width;
                    i_box_height <= word_on_bus.box_height;
                    i_score <= word_on_bus.score;
                    i_last_score <= word_on_bus.last_score;
                    i_last_box <= word_on_bus.last_box;
                    push <= 1'b1;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_boxes.size() == 0) begin
                    if (mismatches < 10)
                        $display("Unexpected result word: box %0d class %0d conf %0d",
                                 o_box_index, o_class_index, o_confidence);
                    mismatches++;
                end else begin
                    oldest_box = expected_boxes.pop_front();
                    if (o_box_index !== oldest_box.box_index
                        || o_class_index !== oldest_box.class_index
                        || o_confidence !== oldest_box.confidence
                        || o_left !== oldest_box.left || o_top !== oldest_box.top
                        || o_right !== oldest_box.right || o_bottom !== oldest_box.bottom) begin
                        if (mismatches < 10) begin
                            $display("Mismatch expected: box %0d class %0d conf %0d ltrb %0d %0d %0d %0d",
                                     oldest_box.box_index, $signed(oldest_box.class_index),
                                     oldest_box.confidence, oldest_box.left, oldest_box.top,
                                     oldest_box.right, oldest_box.bottom);
                            $display("         actual:   box %0d class %0d conf %0d ltrb %0d %0d %0d %0d",
                                     o_box_index, o_class_index, o_confidence,
                                     o_left, o_top, o_right, o_bottom);
                        end
                        mismatches++;
                    end
                    boxes_checked++;
                end
            end
            pop <= !(idle_on && $urandom_range(0, 99) < 17);
        end
    end

    initial begin
        #30ms;
        $display("** detection_box_decode_filter: FAILED **");
        $finish;
    end

    initial begin
        int n;
        int k;
        int p;
        int half;
        int made;
        int hot;
        int r;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [15:0] bw;
        logic signed [15:0] bh;
        logic [15:0] sc;
        logic [15:0] prev_sc;
        bit noisy;

        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = REG_THRESHOLD;
        i_cfg_data = '0;
        cfg_threshold = 16'd16384;
        cfg_pad_left = '0;
        cfg_pad_top = '0;
        cfg_scale = 16'd4096;
        cfg_img_w = 13'd640;
        cfg_img_h = 13'd640;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration: equal scores, mirrored boxes, field extremes, frame end.
        add_word(5120, 5120, 1600, 800, 0, 0, 0);
        add_word(5120, 5120, 1600, 800, 20000, 0, 0);
        add_word(5120, 5120, 1600, 800, 20000, 1, 0);
        add_word(5120, 5120, -1600, -800, 65535, 1, 0);
        add_word(32767, 32767, 32767, 32767, 16384, 1, 0);
        add_word(-32768, -32768, -32768, -32768, 16383, 1, 0);
        add_word(-32768, 100, 32767, -1, 5, 0, 1);
        add_word(-32768, 100, 32767, -1, 65535, 1, 0);
        add_word(2000, 3000, 400, 600, 40000, 1, 1);
        add_word(2000, 3000, 400, 600, 0, 0, 0);
        add_word(2000, 3000, 400, 600, 50000, 1, 0);
        add_word(100, 100, 100, 100, 0, 0, 0);
        add_word(100, 100, 100, 100, 0, 1, 0);
        // A box with more scores than classes, best score after the class wrap.
        for (k = 0; k < 130; k++) begin
            add_word(3000, 2500, 900, 700, (k == 129) ? 16'hFFFF : 16'(k * 300),
                     k == 129, 1'b0);
        end
        settle();

        // Zero threshold, zero scale and zero image size.
        write_reg(REG_THRESHOLD, 16'd0);
        write_reg(REG_PAD_LEFT, 16'd0);
        write_reg(REG_PAD_TOP, 16'd0);
        write_reg(REG_SCALE, 16'd0);
        write_reg(REG_IMAGE_W, 16'd0);
        write_reg(REG_IMAGE_H, 16'd0);
        write_reg(REG_SPARE_A, 16'hFFFF);
        close_cfg();
        add_word(1000, 1000, 200, 200, 0, 0, 0);
        add_word(1000, 1000, 200, 200, 0, 1, 0);
        add_word(32767, -32768, 32767, 32767, 7, 1, 1);
        settle();

        // Maximum threshold and padding, unit scale, oversized image bounds.
        write_reg(REG_THRESHOLD, 16'hFFFF);
        write_reg(REG_PAD_LEFT, 16'hFFFF);
        write_reg(REG_PAD_TOP, 16'h7FFF);
        write_reg(REG_SCALE, 16'd1);
        write_reg(REG_IMAGE_W, 16'hFFFF);
        write_reg(REG_IMAGE_H, 16'd4097);
        write_reg(REG_SPARE_B, 16'h5A5A);
        close_cfg();
        add_word(32767, 32767, 32767, 32767, 65535, 1, 0);
        add_word(32767, 32767, 32767, 32767, 65534, 1, 0);
        add_word(-32768, 32767, -32768, -32768, 65535, 1, 1);
        settle();

        for (p = 0; p < 7; p++) begin
            idle_on = (p != 3);
            r = $urandom_range(0, 9);
            write_reg(REG_THRESHOLD, (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF
                                     : 16'($urandom_range(0, 45000)));
            write_reg(REG_PAD_LEFT, (r == 2) ? 16'($urandom) : 16'($urandom_range(0, 2000)));
            write_reg(REG_PAD_TOP, (r == 3) ? 16'($urandom) : 16'($urandom_range(0, 2000)));
            r = $urandom_range(0, 9);
            write_reg(REG_SCALE, (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : (r == 2) ? 16'd1
                                 : (r == 3) ? 16'($urandom) : 16'($urandom_range(1024, 16384)));
            r = $urandom_range(0, 9);
            write_reg(REG_IMAGE_W, (r == 0) ? 16'd1 : (r == 1) ? 16'($urandom)
                                   : 16'($urandom_range(1, 4096)));
            write_reg(REG_IMAGE_H, (r == 2) ? 16'd4096 : (r == 3) ? 16'($urandom)
                                   : 16'($urandom_range(1, 4096)));
            write_reg(REG_SPARE_A, 16'($urandom));
            write_reg(REG_SPARE_B, 16'($urandom));
            close_cfg();
            for (half = 0; half < 2; half++) begin
                made = 0;
                while (made < 36) begin
                    n = ($urandom_range(0, 49) == 0) ? $urandom_range(129, 140)
                                                     : $urandom_range(1, 6);
                    hot = (n > 128) ? $urandom_range(128, n - 1) : 0;
                    noisy = ($urandom_range(0, 9) == 0);
                    if ($urandom_range(0, 4) == 0) begin
                        cx = 16'($urandom);
                        cy = 16'($urandom);
                        bw = 16'($urandom);
                        bh = 16'($urandom);
                    end else begin
                        cx = 16'($urandom_range(0, 11000));
                        cy = 16'($urandom_range(0, 11000));
                        bw = 16'($urandom_range(0, 4000));
                        bh = 16'($urandom_range(0, 4000));
                        if ($urandom_range(0, 9) == 0) bw = -bw;
                        if ($urandom_range(0, 9) == 0) bh = -bh;
                    end
                    prev_sc = '0;
                    for (k = 0; k < n; k++) begin
                        r = $urandom_range(0, 9);
                        sc = (r == 0) ? 16'd0 : (r == 1) ? prev_sc : 16'($urandom);
                        if (n > 128) sc = (k == hot) ? 16'hFFFF : {1'b0, sc[14:0]};
                        if (noisy) begin
                            cx = 16'($urandom);
                            bh = 16'($urandom);
                        end
                        add_word(cx, cy, bw, bh, sc, k == n - 1,
                                 (k == n - 1) ? ($urandom_range(0, 19) == 0)
                                              : (noisy && $urandom_range(0, 1) == 1));
                        prev_sc = sc;
                    end
                    made += n;
                end
                settle();
            end
        end
        idle_on = 1'b1;

        // A short frame under the highest threshold, nearly all boxes dropped.
        write_reg(REG_THRESHOLD, 16'hFFFF);
        write_reg(REG_SCALE, 16'd4096);
        write_reg(REG_IMAGE_W, 16'd4096);
        write_reg(REG_IMAGE_H, 16'd1);
        close_cfg();
        for (k = 0; k < 24; k++) begin
            sc = (k % 8 == 5) ? 16'hFFFF : 16'($urandom_range(0, 65534));
            add_word(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), sc,
                     1'b1, k == 23);
        end
        settle();

        $display("Run took %0d score words over %0d settings and checked %0d kept boxes,",
                 words_taken, settings_used, boxes_checked);
        $display("including class counter wrap, frame ends, zero and saturated bounds.");
        if (mismatches == 0 && expected_boxes.size() == 0) begin
            $display("** detection_box_decode_filter: PASSED **");
        end else begin
            $display("** detection_box_decode_filter: FAILED **");
        end
        $finish;
    end

endmodule
